FILE: sv/timer_ordered_task_scheduler_unit_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef TIMER_ORDERED_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define TIMER_ORDERED_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TOTSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TOTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/totsu_pkg.sv
`timescale 1ns / 1ps
package totsu_pkg;

  localparam int POOL_SLOTS = 32;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  // Request codes
  localparam logic [2:0] REQ_POLL     = 3'd0;
  localparam logic [2:0] REQ_PERIODIC = 3'd1;
  localparam logic [2:0] REQ_SLEEP    = 3'd2;
  localparam logic [2:0] REQ_WAIT     = 3'd3;
  localparam logic [2:0] REQ_ADJUST   = 3'd4;
  localparam logic [2:0] REQ_WAKE     = 3'd5;
  localparam logic [2:0] REQ_CANCEL   = 3'd6;

  // Result codes
  localparam logic [2:0] KIND_DONE     = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_ALLOC    = 3'd2;
  localparam logic [2:0] KIND_FAULT    = 3'd3;
  localparam logic [2:0] KIND_NODUE    = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_TICK_RATE = 2'd0;
  localparam logic [1:0] REG_MAX_IVL   = 2'd1;
  localparam logic [1:0] REG_WAIT_IVL  = 2'd2;

  typedef enum logic [2:0] {
    M_FREE, M_CANCEL, M_SLEEP, M_PERIODIC, M_WAIT, M_WAKE
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_SCHED_WR, ST_CV1, ST_CV2, ST_CV3, ST_ADJ_CHK, ST_WAKE,
    ST_CAN, ST_UPD_CHK, ST_UPD_FIND, ST_UPD_REM, ST_UPD_NEXT, ST_HEAD, ST_HEAD_RUN,
    ST_INS_SCAN, ST_INS_PUT, ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_POP, OP_SEL_H, OP_FAULT, OP_NODUE, OP_PEND_CLR, OP_IDX_CLR,
    OP_IDX_INC, OP_SLOT_INC, OP_UPD_REM, OP_INS_PUT, OP_HEAD_SEL, OP_HEAD_RUN,
    OP_SCHED_WR, OP_CV1, OP_CV2, OP_CV3, OP_WAKE_SET, OP_CAN_HIT, OP_CAN_END
  } op_e;

  typedef struct packed {
    op_e  op;
    logic addr_list;  // slot address taken from the ordered list at the scan index
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       pend;
    logic       fc_zero;
    logic       list_empty;
    logic       idx_end;
    mode_e      mode;
    logic       slot_match;
    logic       key_before;
    logic       not_due;
    logic       hit;
    logic       slot_last;
  } sts_t;

endpackage

FILE: sv/totsu_ctrl.sv
`timescale 1ns / 1ps
module totsu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  totsu_pkg::sts_t sts_i,
  output totsu_pkg::cmd_t cmd_o
);

  totsu_pkg::state_e state_q, state_d;
  logic              upd_q, upd_d;  // inserting on behalf of the pending-update pass

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= totsu_pkg::ST_IDLE;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      upd_q   <= upd_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    upd_d   = upd_q;
    case (state_q)
      totsu_pkg::ST_IDLE: if (in_valid_i) state_d = totsu_pkg::ST_DECODE;
      totsu_pkg::ST_DECODE: begin
        case (sts_i.req)
          totsu_pkg::REQ_POLL: begin
            if (sts_i.pend) begin
              state_d = totsu_pkg::ST_UPD_CHK;
              upd_d   = 1'b1;
            end else begin
              state_d = totsu_pkg::ST_HEAD;
            end
          end
          totsu_pkg::REQ_PERIODIC, totsu_pkg::REQ_SLEEP, totsu_pkg::REQ_WAIT:
            state_d = sts_i.fc_zero ? totsu_pkg::ST_OUT : totsu_pkg::ST_SCHED_WR;
          totsu_pkg::REQ_ADJUST: state_d = totsu_pkg::ST_ADJ_CHK;
          totsu_pkg::REQ_WAKE:   state_d = totsu_pkg::ST_WAKE;
          totsu_pkg::REQ_CANCEL: state_d = totsu_pkg::ST_CAN;
          default:               state_d = totsu_pkg::ST_OUT;
        endcase
      end
      totsu_pkg::ST_SCHED_WR:
        state_d = (sts_i.req == totsu_pkg::REQ_WAIT) ? totsu_pkg::ST_INS_SCAN
                                                      : totsu_pkg::ST_CV1;
      totsu_pkg::ST_CV1: state_d = totsu_pkg::ST_CV2;
      totsu_pkg::ST_CV2: state_d = totsu_pkg::ST_CV3;
      totsu_pkg::ST_CV3:
        state_d = (sts_i.req == totsu_pkg::REQ_ADJUST) ? totsu_pkg::ST_OUT
                                                        : totsu_pkg::ST_INS_SCAN;
      totsu_pkg::ST_ADJ_CHK:
        state_d = (sts_i.mode != totsu_pkg::M_FREE) ? totsu_pkg::ST_CV1 : totsu_pkg::ST_OUT;
      totsu_pkg::ST_WAKE: state_d = totsu_pkg::ST_OUT;
      totsu_pkg::ST_CAN: if (sts_i.idx_end) state_d = totsu_pkg::ST_OUT;
      totsu_pkg::ST_UPD_CHK:
        state_d = (sts_i.mode == totsu_pkg::M_CANCEL || sts_i.mode == totsu_pkg::M_WAKE)
                  ? totsu_pkg::ST_UPD_FIND : totsu_pkg::ST_UPD_NEXT;
      totsu_pkg::ST_UPD_FIND: begin
        if (sts_i.idx_end) state_d = totsu_pkg::ST_UPD_NEXT;
        else if (sts_i.slot_match) state_d = totsu_pkg::ST_UPD_REM;
      end
      totsu_pkg::ST_UPD_REM:
        state_d = (sts_i.mode == totsu_pkg::M_CANCEL) ? totsu_pkg::ST_UPD_NEXT
                                                       : totsu_pkg::ST_INS_SCAN;
      totsu_pkg::ST_UPD_NEXT: begin
        if (sts_i.slot_last) begin
          state_d = totsu_pkg::ST_HEAD;
          upd_d   = 1'b0;
        end else begin
          state_d = totsu_pkg::ST_UPD_CHK;
        end
      end
      totsu_pkg::ST_HEAD:
        state_d = sts_i.list_empty ? totsu_pkg::ST_OUT : totsu_pkg::ST_HEAD_RUN;
      totsu_pkg::ST_HEAD_RUN:
        state_d = (sts_i.not_due || sts_i.mode == totsu_pkg::M_CANCEL)
                  ? totsu_pkg::ST_OUT : totsu_pkg::ST_INS_SCAN;
      totsu_pkg::ST_INS_SCAN:
        if (sts_i.idx_end || sts_i.key_before) state_d = totsu_pkg::ST_INS_PUT;
      totsu_pkg::ST_INS_PUT:
        state_d = upd_q ? totsu_pkg::ST_UPD_NEXT : totsu_pkg::ST_OUT;
      totsu_pkg::ST_OUT: if (out_ready_i) state_d = totsu_pkg::ST_IDLE;
      default: state_d = totsu_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o.op        = totsu_pkg::OP_NONE;
    cmd_o.addr_list = 1'b0;
    case (state_q)
      totsu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = totsu_pkg::OP_LOAD;
      end
      totsu_pkg::ST_DECODE: begin
        case (sts_i.req)
          totsu_pkg::REQ_POLL:
            if (sts_i.pend) cmd_o.op = totsu_pkg::OP_PEND_CLR;
          totsu_pkg::REQ_PERIODIC, totsu_pkg::REQ_SLEEP, totsu_pkg::REQ_WAIT:
            cmd_o.op = sts_i.fc_zero ? totsu_pkg::OP_FAULT : totsu_pkg::OP_POP;
          totsu_pkg::REQ_ADJUST, totsu_pkg::REQ_WAKE: cmd_o.op = totsu_pkg::OP_SEL_H;
          totsu_pkg::REQ_CANCEL: cmd_o.op = totsu_pkg::OP_IDX_CLR;
          default: cmd_o.op = totsu_pkg::OP_NONE;
        endcase
      end
      totsu_pkg::ST_SCHED_WR: cmd_o.op = totsu_pkg::OP_SCHED_WR;
      totsu_pkg::ST_CV1:      cmd_o.op = totsu_pkg::OP_CV1;
      totsu_pkg::ST_CV2:      cmd_o.op = totsu_pkg::OP_CV2;
      totsu_pkg::ST_CV3:      cmd_o.op = totsu_pkg::OP_CV3;
      totsu_pkg::ST_WAKE:     cmd_o.op = totsu_pkg::OP_WAKE_SET;
      totsu_pkg::ST_CAN: begin
        cmd_o.addr_list = 1'b1;
        if (sts_i.idx_end) cmd_o.op = totsu_pkg::OP_CAN_END;
        else if (sts_i.hit) cmd_o.op = totsu_pkg::OP_CAN_HIT;
        else cmd_o.op = totsu_pkg::OP_IDX_INC;
      end
      totsu_pkg::ST_UPD_CHK:
        if (sts_i.mode == totsu_pkg::M_CANCEL || sts_i.mode == totsu_pkg::M_WAKE)
          cmd_o.op = totsu_pkg::OP_IDX_CLR;
      totsu_pkg::ST_UPD_FIND: begin
        cmd_o.addr_list = 1'b1;
        if (!sts_i.idx_end && !sts_i.slot_match) cmd_o.op = totsu_pkg::OP_IDX_INC;
      end
      totsu_pkg::ST_UPD_REM: cmd_o.op = totsu_pkg::OP_UPD_REM;
      totsu_pkg::ST_UPD_NEXT:
        if (!sts_i.slot_last) cmd_o.op = totsu_pkg::OP_SLOT_INC;
      totsu_pkg::ST_HEAD:
        cmd_o.op = sts_i.list_empty ? totsu_pkg::OP_NODUE : totsu_pkg::OP_HEAD_SEL;
      totsu_pkg::ST_HEAD_RUN: begin
        if (sts_i.not_due) cmd_o.op = totsu_pkg::OP_NODUE;
        else if (sts_i.mode != totsu_pkg::M_CANCEL) cmd_o.op = totsu_pkg::OP_HEAD_RUN;
      end
      totsu_pkg::ST_INS_SCAN: begin
        cmd_o.addr_list = 1'b1;
        if (!sts_i.idx_end && !sts_i.key_before) cmd_o.op = totsu_pkg::OP_IDX_INC;
      end
      totsu_pkg::ST_INS_PUT: cmd_o.op = totsu_pkg::OP_INS_PUT;
      totsu_pkg::ST_OUT: out_valid_o = 1'b1;
      default: cmd_o.op = totsu_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: sv/totsu_dp.sv
`timescale 1ns / 1ps
module totsu_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  totsu_pkg::cmd_t              cmd_i,
  output totsu_pkg::sts_t              sts_o,
  input  logic [31:0]                  tick_rate_i,
  input  logic [31:0]                  max_ivl_i,
  input  logic [30:0]                  wait_ivl_i,
  input  logic [2:0]                   req_type_i,
  input  logic [31:0]                  now_ticks_i,
  input  logic [31:0]                  interval_fixed_i,
  input  logic [totsu_pkg::SLOT_W-1:0] task_handle_i,
  input  logic [31:0]                  callback_key_i,
  input  logic [31:0]                  context_key_i,
  output logic [2:0]                   result_kind_o,
  output logic [totsu_pkg::SLOT_W-1:0] slot_id_o,
  output logic [31:0]                  dispatch_callback_o,
  output logic [31:0]                  dispatch_context_o,
  output logic [totsu_pkg::CNT_W-1:0]  cancelled_count_o
);

  localparam int N  = totsu_pkg::POOL_SLOTS;
  localparam int SW = totsu_pkg::SLOT_W;
  localparam int CW = totsu_pkg::CNT_W;

  // Slot pool and lists
  totsu_pkg::mode_e mode_q [N];
  logic [31:0]      due_q  [N];
  logic [31:0]      per_q  [N];
  logic [31:0]      cb_q   [N];
  logic [31:0]      cx_q   [N];
  logic [SW-1:0]    list_q [N];
  logic [SW-1:0]    stk_q  [N];
  logic [CW-1:0]    lcnt_q, fc_q;
  logic             pend_q;

  // Working registers
  logic [CW-1:0] idx_q, cnt_q;
  logic [SW-1:0] slot_q;
  logic [2:0]    req_q;
  logic [31:0]   now_q, ivl_q, kcb_q, kcx_q, key_q, fx_q;
  logic [SW-1:0] h_q;
  logic [63:0]   prod_q;

  // Result registers
  logic [2:0]    kind_q;
  logic [SW-1:0] rslot_q;
  logic [31:0]   rcb_q, rcx_q;

  logic [SW-1:0]    ad;
  totsu_pkg::mode_e m;
  logic [31:0]      due_rd, ticks, new_due, wait32;
  logic             match;

  assign ad     = cmd_i.addr_list ? list_q[idx_q[SW-1:0]] : slot_q;
  assign m      = mode_q[ad];
  assign due_rd = due_q[ad];
  assign wait32 = {1'b0, wait_ivl_i};
  assign ticks  = (prod_q[63:56] != 8'd0) ? 32'hFFFF_FFFF : prod_q[55:24];
  assign new_due = per_q[ad] + ((m == totsu_pkg::M_PERIODIC) ? due_rd : now_q);

  // Cancel match: a zero callback key matches on context alone; else a zero context key matches on callback alone
  always_comb begin
    if (kcb_q == 32'd0) match = (cx_q[ad] == kcx_q);
    else if (kcx_q == 32'd0) match = (cb_q[ad] == kcb_q);
    else match = (cb_q[ad] == kcb_q) && (cx_q[ad] == kcx_q);
  end

  // Status to the controller
  always_comb begin
    sts_o.req        = req_q;
    sts_o.pend       = pend_q;
    sts_o.fc_zero    = (fc_q == CW'(0));
    sts_o.list_empty = (lcnt_q == CW'(0));
    sts_o.idx_end    = (idx_q == lcnt_q);
    sts_o.mode       = m;
    sts_o.slot_match = (list_q[idx_q[SW-1:0]] == slot_q);
    sts_o.key_before = (key_q - due_rd) >= 32'h8000_0000;
    sts_o.not_due    = (now_q - due_rd) >= 32'h8000_0000;
    sts_o.hit        = match && (m != totsu_pkg::M_CANCEL) && (m != totsu_pkg::M_FREE);
    sts_o.slot_last  = (slot_q == SW'(N - 1));
  end

  // Control-bearing state: modes, free stack, counts, scan pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N; j++) begin
        mode_q[j] <= totsu_pkg::M_FREE;
        stk_q[j]  <= SW'(N - 1 - j);
      end
      fc_q   <= CW'(N);
      lcnt_q <= '0;
      pend_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
      slot_q <= '0;
    end else begin
      case (cmd_i.op)
        totsu_pkg::OP_LOAD: cnt_q <= '0;
        totsu_pkg::OP_POP: begin
          slot_q <= stk_q[SW'(fc_q - CW'(1))];
          fc_q   <= fc_q - CW'(1);
        end
        totsu_pkg::OP_SEL_H: slot_q <= h_q;
        totsu_pkg::OP_PEND_CLR: begin
          pend_q <= 1'b0;
          slot_q <= '0;
        end
        totsu_pkg::OP_IDX_CLR: idx_q <= '0;
        totsu_pkg::OP_IDX_INC: idx_q <= idx_q + CW'(1);
        totsu_pkg::OP_SLOT_INC: slot_q <= slot_q + SW'(1);
        totsu_pkg::OP_UPD_REM: begin
          lcnt_q <= lcnt_q - CW'(1);
          if (m == totsu_pkg::M_CANCEL) begin
            mode_q[ad]           <= totsu_pkg::M_FREE;
            stk_q[fc_q[SW-1:0]]  <= slot_q;
            fc_q                 <= fc_q + CW'(1);
          end else begin
            idx_q <= '0;
          end
        end
        totsu_pkg::OP_INS_PUT: lcnt_q <= lcnt_q + CW'(1);
        totsu_pkg::OP_HEAD_SEL: begin
          slot_q <= list_q[0];
          idx_q  <= '0;
        end
        totsu_pkg::OP_HEAD_RUN: begin
          if (m == totsu_pkg::M_WAKE) mode_q[ad] <= totsu_pkg::M_WAIT;
          lcnt_q <= lcnt_q - CW'(1);
          idx_q  <= '0;
        end
        totsu_pkg::OP_SCHED_WR: begin
          case (req_q)
            totsu_pkg::REQ_PERIODIC: mode_q[ad] <= totsu_pkg::M_PERIODIC;
            totsu_pkg::REQ_SLEEP:    mode_q[ad] <= totsu_pkg::M_SLEEP;
            default:                 mode_q[ad] <= totsu_pkg::M_WAIT;
          endcase
          idx_q <= '0;
        end
        totsu_pkg::OP_CV3: idx_q <= '0;
        totsu_pkg::OP_WAKE_SET: begin
          if (m != totsu_pkg::M_FREE && m != totsu_pkg::M_CANCEL) begin
            mode_q[ad] <= totsu_pkg::M_WAKE;
            pend_q     <= 1'b1;
          end
        end
        totsu_pkg::OP_CAN_HIT: begin
          mode_q[ad] <= totsu_pkg::M_CANCEL;
          cnt_q      <= cnt_q + CW'(1);
          idx_q      <= idx_q + CW'(1);
        end
        totsu_pkg::OP_CAN_END: if (cnt_q != CW'(0)) pend_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload stores, request fields, conversion pipeline and results
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      totsu_pkg::OP_LOAD: begin
        req_q   <= req_type_i;
        now_q   <= now_ticks_i;
        ivl_q   <= interval_fixed_i;
        h_q     <= task_handle_i;
        kcb_q   <= callback_key_i;
        kcx_q   <= context_key_i;
        kind_q  <= totsu_pkg::KIND_DONE;
        rslot_q <= '0;
        rcb_q   <= '0;
        rcx_q   <= '0;
      end
      totsu_pkg::OP_FAULT: kind_q <= totsu_pkg::KIND_FAULT;
      totsu_pkg::OP_NODUE: kind_q <= totsu_pkg::KIND_NODUE;
      totsu_pkg::OP_UPD_REM: begin
        for (int j = 0; j < N - 1; j++)
          if (CW'(j) >= idx_q) list_q[j] <= list_q[j + 1];
        if (m != totsu_pkg::M_CANCEL) begin
          due_q[ad] <= now_q;
          key_q     <= now_q;
        end
      end
      totsu_pkg::OP_INS_PUT: begin
        for (int j = 1; j < N; j++)
          if (CW'(j) > idx_q && CW'(j) <= lcnt_q) list_q[j] <= list_q[j - 1];
        list_q[idx_q[SW-1:0]] <= slot_q;
      end
      totsu_pkg::OP_HEAD_RUN: begin
        if (m != totsu_pkg::M_WAIT) begin
          kind_q  <= totsu_pkg::KIND_DISPATCH;
          rslot_q <= slot_q;
          rcb_q   <= cb_q[ad];
          rcx_q   <= cx_q[ad];
        end
        due_q[ad] <= new_due;
        key_q     <= new_due;
        for (int j = 0; j < N - 1; j++) list_q[j] <= list_q[j + 1];
      end
      totsu_pkg::OP_SCHED_WR: begin
        cb_q[ad] <= kcb_q;
        cx_q[ad] <= kcx_q;
        kind_q   <= totsu_pkg::KIND_ALLOC;
        rslot_q  <= slot_q;
        if (req_q == totsu_pkg::REQ_WAIT) begin
          per_q[ad] <= wait32;
          due_q[ad] <= now_q + wait32;
          key_q     <= now_q + wait32;
        end
      end
      totsu_pkg::OP_CV1: fx_q <= (ivl_q > max_ivl_i) ? max_ivl_i : ivl_q;
      totsu_pkg::OP_CV2: prod_q <= 64'(fx_q) * 64'(tick_rate_i);
      totsu_pkg::OP_CV3: begin
        per_q[ad] <= ticks;
        if (req_q != totsu_pkg::REQ_ADJUST) begin
          due_q[ad] <= now_q + ticks;
          key_q     <= now_q + ticks;
        end
      end
      totsu_pkg::OP_CAN_HIT: begin
        cb_q[ad] <= '0;
        cx_q[ad] <= '0;
      end
      default: ;
    endcase
  end

  assign result_kind_o       = kind_q;
  assign slot_id_o           = rslot_q;
  assign dispatch_callback_o = rcb_q;
  assign dispatch_context_o  = rcx_q;
  assign cancelled_count_o   = (req_q == totsu_pkg::REQ_CANCEL) ? cnt_q : '0;

endmodule

FILE: sv/timer_ordered_task_scheduler_unit.sv
`timescale 1ns / 1ps
// Work, accept to result: a schedule runs the 8.24 interval conversion (clamp, multiply, scale;
// skipped by wait), then one list scan step per entry passed; a pool fault skips both; cancel
// scans the whole list; a poll with an update pending first walks every slot, searching the
// list for each cancelled or woken one. Throughput: one transaction at a time, set by the scans.
// Reset (async, active low): all slots free, list empty, free stack 0..31 with 0 on top,
// registers back to their defaults; no clearing pass.
module timer_ordered_task_scheduler_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   req_type_i,
  input  logic [31:0]                  now_ticks_i,
  input  logic [31:0]                  interval_fixed_i,
  input  logic [totsu_pkg::SLOT_W-1:0] task_handle_i,
  input  logic [31:0]                  callback_key_i,
  input  logic [31:0]                  context_key_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   result_kind_o,
  output logic [totsu_pkg::SLOT_W-1:0] slot_id_o,
  output logic [31:0]                  dispatch_callback_o,
  output logic [31:0]                  dispatch_context_o,
  output logic [totsu_pkg::CNT_W-1:0]  cancelled_count_o
);

  `include "timer_ordered_task_scheduler_unit_assert.svh"

  logic [31:0] tick_rate_q, max_ivl_q;
  logic [30:0] wait_ivl_q;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  totsu_pkg::cmd_t cmd;
  totsu_pkg::sts_t sts;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= 32'd1000000;
      max_ivl_q   <= 32'd268435455;
      wait_ivl_q  <= 31'h7FFF_FFFF;
    end else if (cfg_wr) begin
      case (reg_idx)
        totsu_pkg::REG_TICK_RATE: tick_rate_q <= pwdata;
        totsu_pkg::REG_MAX_IVL:   max_ivl_q   <= pwdata;
        totsu_pkg::REG_WAIT_IVL:  wait_ivl_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      totsu_pkg::REG_TICK_RATE: prdata = tick_rate_q;
      totsu_pkg::REG_MAX_IVL:   prdata = max_ivl_q;
      totsu_pkg::REG_WAIT_IVL:  prdata = {1'b0, wait_ivl_q};
      default:                  prdata = '0;
    endcase
  end

  totsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  totsu_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .tick_rate_i         (tick_rate_q),
    .max_ivl_i           (max_ivl_q),
    .wait_ivl_i          (wait_ivl_q),
    .req_type_i          (req_type_i),
    .now_ticks_i         (now_ticks_i),
    .interval_fixed_i    (interval_fixed_i),
    .task_handle_i       (task_handle_i),
    .callback_key_i      (callback_key_i),
    .context_key_i       (context_key_i),
    .result_kind_o       (result_kind_o),
    .slot_id_o           (slot_id_o),
    .dispatch_callback_o (dispatch_callback_o),
    .dispatch_context_o  (dispatch_context_o),
    .cancelled_count_o   (cancelled_count_o)
  );

  // Checks
  `TOTSU_ASSERT_NOW(a_one_side, out_valid_o, !in_ready_o, "ready while result pending")
  `TOTSU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o, "not busy after accept")
  `TOTSU_ASSERT_NOW(a_slot_zero, out_valid_o && result_kind_o != totsu_pkg::KIND_DISPATCH && result_kind_o != totsu_pkg::KIND_ALLOC, slot_id_o == '0, "slot id without dispatch or allocation")

endmodule
